@@ rtl/core/b64d_pkg.sv @@
// Shared types and constants of the base64 text decoder.
// Used by the front end, the job queue, the back end and the top level.
`default_nettype none

package b64d_pkg;

    // Characters that steer the decoder.
    localparam logic [7:0] CHAR_NUL   = 8'd0;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_SLASH = 8'd47;
    localparam logic [7:0] CHAR_PAD   = 8'd61;

    localparam int REPORT_BITS = 16;
    localparam int CAP_BITS    = 16;

    // Depth of the job queue between the front and the back end.
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_EXPECTED    = 2'd1,
        ST_BAD_PADDING = 2'd2,
        ST_NO_SPACE    = 2'd3
    } t_status;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    // One unit of work for the back end: a decoded group of one to three
    // bytes, or the final status of a text.
    typedef struct packed {
        t_kind                  kind;
        logic [1:0]             nbytes;
        logic [2:0][7:0]        data;
        t_status                status;
        logic [REPORT_BITS-1:0] chars;
        logic [REPORT_BITS-1:0] bytes;
    } t_job;

    // Queue state as seen by its two users.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

`default_nettype wire

@@ rtl/core/b64d_front.sv @@
// Front end of the base64 text decoder: classifies each character, keeps
// the group and count state and issues jobs. Depends on b64d_pkg.
`default_nettype none

module b64d_front #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [7:0]                    i_character,
    input  wire logic                          i_cfg_we,
    input  wire logic [b64d_pkg::CAP_BITS-1:0] i_cfg_wdata,
    output b64d_pkg::t_job                     o_job,
    output logic                               o_job_valid
);
    import b64d_pkg::*;

    localparam int CMP_BITS = COUNT_BITS + CAP_BITS + 1;

    logic [CAP_BITS-1:0]   r_capacity;
    logic [2:0][5:0]       r_sextet;
    logic [2:0]            r_is_pad;
    logic [1:0]            r_fill,     n_fill;
    logic [COUNT_BITS-1:0] r_position, n_position;
    logic [COUNT_BITS-1:0] r_total,    n_total;
    logic                  r_error,    n_error;
    logic                  n_store;

    logic [6:0]            decoded;
    logic                  is_pad;
    logic                  is_space;
    logic [COUNT_BITS-1:0] pos_inc;
    logic [1:0]            nbytes;
    logic [5:0]            s2;
    logic [5:0]            s3;
    logic                  pad_bad;
    logic                  no_space;

    // Bit 6 set means the character is not in the alphabet.
    function automatic logic [6:0] sextet(input logic [7:0] c);
        logic [6:0] v;
        priority if (c >= 8'd65 && c <= 8'd90) begin
            v = 7'(c - 8'd65);
        end else if (c >= 8'd97 && c <= 8'd122) begin
            v = 7'(c - 8'd71);
        end else if (c >= 8'd48 && c <= 8'd57) begin
            v = 7'(c + 8'd4);
        end else if (c == CHAR_PLUS) begin
            v = 7'd62;
        end else if (c == CHAR_SLASH) begin
            v = 7'd63;
        end else begin
            v = 7'h40;
        end
        return v;
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v,
                                                      input logic [1:0] n);
        logic [COUNT_BITS:0] s;
        s = {1'b0, v} + (COUNT_BITS+1)'(n);
        return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

    function automatic logic [REPORT_BITS-1:0] report(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS+REPORT_BITS-1:0] w;
        w = (COUNT_BITS+REPORT_BITS)'(v);
        return (w > (COUNT_BITS+REPORT_BITS)'({REPORT_BITS{1'b1}})) ?
               {REPORT_BITS{1'b1}} : w[REPORT_BITS-1:0];
    endfunction

    assign decoded  = sextet(i_character);
    assign is_pad   = (i_character == CHAR_PAD);
    assign is_space = (i_character == CHAR_SPACE) || (i_character == CHAR_TAB) ||
                      (i_character == CHAR_CR) || (i_character == CHAR_LF);
    assign pos_inc  = sat_inc(r_position, 2'd1);

    // Checks done when the fourth character of a group arrives.
    assign pad_bad  = r_is_pad[0] || r_is_pad[1] || (r_is_pad[2] && !is_pad);
    assign nbytes   = 2'd1 + {1'b0, !r_is_pad[2]} + {1'b0, !is_pad};
    assign no_space = (CMP_BITS'(r_total) + CMP_BITS'(nbytes)) > CMP_BITS'(r_capacity);
    assign s2       = r_is_pad[2] ? 6'd0 : r_sextet[2];
    assign s3       = is_pad ? 6'd0 : decoded[5:0];

    always_comb begin
        n_fill      = r_fill;
        n_position  = r_position;
        n_total     = r_total;
        n_error     = r_error;
        n_store     = 1'b0;
        o_job_valid = 1'b0;
        o_job.kind    = KIND_STATUS;
        o_job.nbytes  = nbytes;
        o_job.data[0] = {r_sextet[0], r_sextet[1][5:4]};
        o_job.data[1] = {r_sextet[1][3:0], s2[5:2]};
        o_job.data[2] = {s2[1:0], s3};
        o_job.status  = ST_OK;
        o_job.chars   = report(r_position);
        o_job.bytes   = report(r_total);
        if (i_accept) begin
            priority if (r_error) begin
                if (i_character == CHAR_NUL) begin
                    n_fill     = 2'd0;
                    n_position = '0;
                    n_total    = '0;
                    n_error    = 1'b0;
                end
            end else if (i_character == CHAR_NUL) begin
                o_job_valid  = 1'b1;
                o_job.status = (r_fill != 2'd0) ? ST_EXPECTED : ST_OK;
                n_fill       = 2'd0;
                n_position   = '0;
                n_total      = '0;
            end else if (is_space) begin
                n_position = pos_inc;
            end else if (decoded[6] && !is_pad) begin
                o_job_valid  = 1'b1;
                o_job.status = ST_EXPECTED;
                n_error      = 1'b1;
            end else if (r_fill != 2'd3) begin
                n_position = pos_inc;
                n_store    = 1'b1;
                n_fill     = r_fill + 2'd1;
            end else begin
                n_position = pos_inc;
                n_fill     = 2'd0;
                o_job_valid = 1'b1;
                o_job.chars = report(pos_inc);
                priority if (pad_bad) begin
                    o_job.status = ST_BAD_PADDING;
                    n_error      = 1'b1;
                end else if (no_space) begin
                    o_job.status = ST_NO_SPACE;
                    n_error      = 1'b1;
                end else begin
                    o_job.kind = KIND_DATA;
                    n_total    = sat_inc(r_total, nbytes);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= {CAP_BITS{1'b1}};
            r_fill     <= 2'd0;
            r_position <= '0;
            r_total    <= '0;
            r_error    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            r_fill     <= n_fill;
            r_position <= n_position;
            r_total    <= n_total;
            r_error    <= n_error;
        end
    end

    // Group slots hold the sextet and a padding flag; they need no reset.
    always_ff @(posedge i_clk) begin
        if (n_store) begin
            r_sextet[r_fill] <= is_pad ? 6'd0 : decoded[5:0];
            r_is_pad[r_fill] <= is_pad;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/b64d_queue.sv @@
// Short job queue that decouples the decoder front end from the back end.
// Depends on b64d_pkg for the job type and depth.
`default_nettype none

module b64d_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  b64d_pkg::t_job i_job,
    input  wire logic      i_pop,
    output b64d_pkg::t_job o_head,
    output b64d_pkg::t_q_flags o_flags
);
    import b64d_pkg::*;

    t_job                  r_slot [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr_ptr;
    logic [Q_PTR_BITS-1:0] r_rd_ptr;
    logic [Q_CNT_BITS-1:0] r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_flags.full  = (r_count == Q_CNT_BITS'(Q_DEPTH));
    assign o_flags.empty = (r_count == '0);
    assign do_push       = i_push && !o_flags.full;
    assign do_pop        = i_pop && !o_flags.empty;
    assign o_head        = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= Q_PTR_BITS'((32'(r_wr_ptr) + 1) % Q_DEPTH);
            end
            if (do_pop) begin
                r_rd_ptr <= Q_PTR_BITS'((32'(r_rd_ptr) + 1) % Q_DEPTH);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/b64d_back.sv @@
// Back end of the base64 text decoder: turns the job at the queue head into
// one to three data results or one status result. Depends on b64d_pkg.
`default_nettype none

module b64d_back (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  b64d_pkg::t_job                        i_head,
    input  b64d_pkg::t_q_flags                    i_flags,
    input  wire logic                             i_pop,
    output logic                                  o_q_pop,
    output logic                                  o_empty,
    output logic                                  o_kind,
    output logic [7:0]                            o_data_byte,
    output logic [1:0]                            o_status,
    output logic [b64d_pkg::REPORT_BITS-1:0]      o_chars_consumed,
    output logic [b64d_pkg::REPORT_BITS-1:0]      o_bytes_written,
    output logic                                  o_last
);
    import b64d_pkg::*;

    // Index of the byte of the head job that is on the result ports.
    logic [1:0] r_idx, n_idx;
    logic       is_status;
    logic       take;
    logic       job_done;

    assign is_status = (i_head.kind == KIND_STATUS);
    assign o_empty   = i_flags.empty;
    assign take      = i_pop && !i_flags.empty;
    assign job_done  = is_status || (r_idx == i_head.nbytes - 2'd1);
    assign o_q_pop   = take && job_done;

    always_comb begin
        n_idx = r_idx;
        if (take) begin
            n_idx = job_done ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_comb begin
        o_kind           = is_status;
        o_last           = is_status;
        o_data_byte      = '0;
        o_status         = ST_OK;
        o_chars_consumed = '0;
        o_bytes_written  = '0;
        if (is_status) begin
            o_status         = i_head.status;
            o_chars_consumed = i_head.chars;
            o_bytes_written  = i_head.bytes;
        end else begin
            o_data_byte = i_head.data[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/base64_text_decoder_top.sv @@
// Top level of the base64 text decoder: front end, job queue and back end.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
// Usage:
//   Input channel: one text character per transaction on i_character,
//   accepted at a clock edge with push high and full low. A character of
//   zero ends the text; space, tab, CR and LF are skipped but counted.
//   Result channel: while empty is low the oldest result is on the o_ ports
//   and is taken at a clock edge with pop high. Each text ends with one
//   status result (o_kind and o_last high) at the terminator or at the
//   first error; after an error characters are dropped up to the terminator.
//   Configuration: i_cfg_we writes i_cfg_wdata into the output capacity.
//   Throughput: one character per cycle in while full is low, one result
//   per cycle out while empty is low; a four-entry job queue between the
//   classifier and the result sequencer sets how much output burst can be
//   absorbed. Reset clears the text state and the queue and sets the
//   capacity to 65535. When the receiver stalls, jobs pile up in the queue
//   and full rises once it holds four jobs; no character is lost or
//   repeated.
`default_nettype none

module base64_text_decoder_top #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic [7:0]                       i_character,
    input  wire logic                             i_cfg_we,
    input  wire logic [b64d_pkg::CAP_BITS-1:0]    i_cfg_wdata,
    output logic                                  empty,
    input  wire logic                             pop,
    output logic                                  o_kind,
    output logic [7:0]                            o_data_byte,
    output logic [1:0]                            o_status,
    output logic [b64d_pkg::REPORT_BITS-1:0]      o_chars_consumed,
    output logic [b64d_pkg::REPORT_BITS-1:0]      o_bytes_written,
    output logic                                  o_last
);
    import b64d_pkg::*;

    t_job     job;
    logic     job_valid;
    t_job     head;
    t_q_flags flags;
    logic     q_pop;
    logic     accept;

    assign full   = flags.full;
    assign accept = push && !flags.full;

    b64d_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_character (i_character),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_job       (job),
        .o_job_valid (job_valid)
    );

    b64d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_job   (job),
        .i_pop   (q_pop),
        .o_head  (head),
        .o_flags (flags)
    );

    b64d_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head),
        .i_flags          (flags),
        .i_pop            (pop),
        .o_q_pop          (q_pop),
        .o_empty          (empty),
        .o_kind           (o_kind),
        .o_data_byte      (o_data_byte),
        .o_status         (o_status),
        .o_chars_consumed (o_chars_consumed),
        .o_bytes_written  (o_bytes_written),
        .o_last           (o_last)
    );

    // The front end only issues a job when the queue has room for it.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(job_valid && flags.full))
        else $error("job issued while the queue was full");

    // A job leaves the queue only with a result transaction.
    a_qpop_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (pop && !empty))
        else $error("queue popped without a result transaction");

    // A status result is always the last one taken from its job.
    a_status_pops_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_kind) |-> q_pop)
        else $error("status result did not retire its job");

    // The queue comes out of reset empty and ready.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queue not empty after reset");

endmodule

`default_nettype wire
